// ----- sv/ibp_pkg.sv -----
// Shared types, constants and coefficient tables for the IIR bandpass unit.
// No dependencies; imported by every module of the block.
package ibp_pkg;

   localparam int NUM_COEFS   = 13;
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 64;
   localparam int COEF_FRAC   = 54;
   localparam int Z_FRAC      = 24;
   localparam int PROD_SHIFT  = COEF_FRAC - Z_FRAC;
   localparam int HALF_BITS   = COEF_BITS / 2;
   localparam int PP_BITS     = SAMPLE_BITS + HALF_BITS;
   localparam int FULL_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int MAG_BITS    = FULL_BITS - PROD_SHIFT;
   localparam int PMAG_BITS   = COEF_BITS - 1;
   localparam int ACC_BITS    = 64;
   localparam int SUM_BITS    = ACC_BITS + 2;
   localparam int Q_BITS      = ACC_BITS + 1 - Z_FRAC;
   localparam int Z_DEPTH     = (NUM_COEFS > 1) ? NUM_COEFS - 1 : 1;
   localparam int IDX_BITS    = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
   localparam int ZIDX_BITS   = (Z_DEPTH > 1) ? $clog2(Z_DEPTH) : 1;
   localparam int SRC_LEN     = 13;

   localparam logic [COEF_BITS-1:0] POS_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};

   typedef logic signed [COEF_BITS-1:0] coef_table_type [NUM_COEFS];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_RND,
      ST_ACC_Y,
      ST_OUT_Y,
      ST_SUB_A,
      ST_WRITE_Z
   } state_type;

   typedef enum logic [1:0] {
      TERM_Y,
      TERM_B,
      TERM_A
   } term_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI,
      MUL_RND
   } mul_phase_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD_P,
      ACC_ADD_P,
      ACC_SUB_P,
      ACC_ADD_Z
   } acc_op_type;

   typedef struct packed {
      logic                x_load;
      mul_phase_type       mul_phase;
      logic                use_y;
      logic                use_den;
      logic [IDX_BITS-1:0] coef_idx;
      acc_op_type          acc_op;
      logic                z_write;
      logic                y_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } ctrl_status_type;

   // decimal source values: mantissa * 10^-exp
   localparam longint B_MANT [SRC_LEN] = '{
      64'sd196388456, 64'sd0, -64'sd117833074, 64'sd0, 64'sd294582684, 64'sd0,
      -64'sd392776912, 64'sd0, 64'sd294582684, 64'sd0, -64'sd117833074, 64'sd0,
      64'sd196388456
   };
   localparam int unsigned B_EXP [SRC_LEN] = '{15, 0, 14, 0, 14, 0, 14, 0, 14, 0, 14, 0, 15};

   localparam longint A_MANT [SRC_LEN] = '{
      64'sd1, -64'sd973518949, 64'sd4489144749, -64'sd12927097137,
      64'sd25844035421, -64'sd37747482575, 64'sd41276768439, -64'sd34041377444,
      64'sd21018376234, -64'sd9481159027, 64'sd2969275540, -64'sd580722751,
      64'sd53800442
   };
   localparam int unsigned A_EXP [SRC_LEN] = '{0, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8};

   // Exact round-half-away-from-zero of mant * 10^-exp10 * 2^54, by restoring long division, clamped to POS_MAX
   function automatic logic signed [COEF_BITS-1:0] to_q54(longint mant, int unsigned exp10);
      logic [63:0]  d;
      logic [63:0]  n;
      logic [64:0]  r;
      logic [127:0] q;
      logic [63:0]  qs;
      logic         bit_in;
      int           i;
      d = 64'd1;
      for (i = 0; i < 18; i++) begin
         if (i < int'(exp10)) d = d * 64'd10;
      end
      n = (mant < 0) ? 64'(-mant) : 64'(mant);
      r = '0;
      q = '0;
      for (i = 0; i < 64 + COEF_FRAC; i++) begin
         bit_in = (i < 64) ? n[63 - i] : 1'b0;
         r = {r[63:0], bit_in};
         q = {q[126:0], 1'b0};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[0] = 1'b1;
         end
      end
      if ({r, 1'b0} >= {2'b00, d}) q = q + 128'd1;
      if (q > 128'(POS_MAX)) q = 128'(POS_MAX);
      qs = q[63:0];
      return (mant < 0) ? -qs : qs;
   endfunction

   function automatic coef_table_type build_table(logic den);
      coef_table_type t;
      int             k;
      for (k = 0; k < NUM_COEFS; k++) begin
         if (k < SRC_LEN)
            t[k] = den ? to_q54(A_MANT[k], A_EXP[k]) : to_q54(B_MANT[k], B_EXP[k]);
         else
            t[k] = '0;
      end
      return t;
   endfunction

   localparam coef_table_type NUM_TABLE = build_table(1'b0);
   localparam coef_table_type DEN_TABLE = build_table(1'b1);

endpackage

// ----- sv/ibp_ctrl.sv -----
// Sequencer for the IIR bandpass unit: walks the multiply/accumulate schedule.
// Depends on ibp_pkg; drives ibp_dp through ctrl_cmd_type.
module ibp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ibp_pkg::ctrl_status_type status,
   output ibp_pkg::ctrl_cmd_type   cmd
);
   import ibp_pkg::*;

   state_type           state_ff, state_in;
   term_type            term_ff, term_in;
   logic [IDX_BITS-1:0] k_ff, k_in;

   localparam logic [IDX_BITS-1:0] K_LAST = IDX_BITS'(NUM_COEFS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_Y;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         k_ff     <= k_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_LO;
               term_in  = TERM_Y;
               k_in     = '0;
            end
         end
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_MUL_RND;
         ST_MUL_RND: begin
            unique case (term_ff)
               TERM_Y: state_in = ST_ACC_Y;
               TERM_B: begin
                  state_in = ST_MUL_LO;
                  term_in  = TERM_A;
               end
               TERM_A:  state_in = ST_SUB_A;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ACC_Y:   state_in = ST_OUT_Y;
         ST_OUT_Y: begin
            if (status.rsp_free) begin
               if (NUM_COEFS > 1) begin
                  state_in = ST_MUL_LO;
                  term_in  = TERM_B;
                  k_in     = IDX_BITS'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUB_A:   state_in = ST_WRITE_Z;
         ST_WRITE_Z: begin
            if (k_ff == K_LAST) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL_LO;
               term_in  = TERM_B;
               k_in     = k_ff + IDX_BITS'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.mul_phase = MUL_NONE;
      cmd.acc_op    = ACC_NONE;
      cmd.coef_idx  = k_ff;
      cmd.use_y     = (term_ff == TERM_A);
      cmd.use_den   = (term_ff == TERM_A);
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.x_load = req_valid;
         end
         ST_MUL_LO: begin
            cmd.mul_phase = MUL_LO;
            // numerator product is already in the product register
            if (term_ff == TERM_A) cmd.acc_op = ACC_LOAD_P;
         end
         ST_MUL_HI:  cmd.mul_phase = MUL_HI;
         ST_MUL_RND: cmd.mul_phase = MUL_RND;
         ST_ACC_Y:   cmd.acc_op    = ACC_ADD_P;
         ST_OUT_Y:   cmd.y_load    = status.rsp_free;
         ST_SUB_A:   cmd.acc_op    = ACC_SUB_P;
         ST_WRITE_Z: begin
            cmd.acc_op  = ACC_ADD_Z;
            cmd.z_write = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/ibp_dp.sv -----
// Datapath of the IIR bandpass unit: shared 24x32 multiplier, saturating
// accumulator, delay line and output register. Depends on ibp_pkg.
module ibp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ibp_pkg::ctrl_cmd_type               cmd,
   output ibp_pkg::ctrl_status_type            status,
   input  logic signed [ibp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ibp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                rsp_clipped
);
   import ibp_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [PP_BITS-1:0]            lo_ff, hi_ff;
   logic                          neg_ff;
   logic [PMAG_BITS-1:0]          p_mag_ff, p_mag_in;
   logic                          p_neg_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [ACC_BITS-1:0]    z_ff [Z_DEPTH];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_clipped_ff;

   // multiplier operands
   logic signed [SAMPLE_BITS-1:0] s;
   logic [SAMPLE_BITS-1:0]        s_mag;
   logic signed [COEF_BITS-1:0]   c;
   logic [COEF_BITS-1:0]          c_mag;
   logic [HALF_BITS-1:0]          half;
   logic [PP_BITS-1:0]            pp;
   logic [FULL_BITS-1:0]          full;
   logic [MAG_BITS-1:0]           mag_wide;

   assign s     = cmd.use_y ? y_ff : x_ff;
   assign s_mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
   assign c     = cmd.use_den ? DEN_TABLE[cmd.coef_idx] : NUM_TABLE[cmd.coef_idx];
   assign c_mag = c[COEF_BITS-1] ? (~c + 1'b1) : c;
   assign half  = (cmd.mul_phase == MUL_HI) ? c_mag[COEF_BITS-1:HALF_BITS]
                                            : c_mag[HALF_BITS-1:0];
   assign pp    = PP_BITS'(s_mag) * PP_BITS'(half);

   // recombine halves, round half away from zero on the magnitude
   assign full     = {hi_ff, {HALF_BITS{1'b0}}} + FULL_BITS'(lo_ff)
                     + (FULL_BITS'(1) << (PROD_SHIFT - 1));
   assign mag_wide = full[FULL_BITS-1:PROD_SHIFT];
   assign p_mag_in = (128'(mag_wide) > 128'(POS_MAX)) ? {PMAG_BITS{1'b1}}
                                                      : PMAG_BITS'(mag_wide);

   // delay line access
   logic                         z_hit;
   logic [ZIDX_BITS-1:0]         rd_idx, wr_idx;
   logic [IDX_BITS-1:0]          wr_full;
   logic signed [ACC_BITS-1:0]   z_rd;

   assign z_hit   = (NUM_COEFS > 1) && (cmd.coef_idx < IDX_BITS'(Z_DEPTH));
   assign rd_idx  = z_hit ? cmd.coef_idx[ZIDX_BITS-1:0] : '0;
   assign z_rd    = z_hit ? z_ff[rd_idx] : '0;
   assign wr_full = cmd.coef_idx - IDX_BITS'(1);
   assign wr_idx  = wr_full[ZIDX_BITS-1:0];

   // saturating adder
   logic signed [SUM_BITS-1:0] add_a, add_b, sum;
   logic                       add_sub;
   logic signed [ACC_BITS-1:0] sum_sat;

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (cmd.acc_op)
         ACC_NONE: begin
            add_a = '0;
         end
         ACC_LOAD_P: begin
            add_b   = SUM_BITS'(p_mag_ff);
            add_sub = p_neg_ff;
         end
         ACC_ADD_P: begin
            add_a   = SUM_BITS'(z_rd);
            add_b   = SUM_BITS'(p_mag_ff);
            add_sub = p_neg_ff;
         end
         ACC_SUB_P: begin
            add_a   = SUM_BITS'(acc_ff);
            add_b   = SUM_BITS'(p_mag_ff);
            add_sub = ~p_neg_ff;
         end
         ACC_ADD_Z: begin
            add_a = SUM_BITS'(z_rd);
            add_b = SUM_BITS'(acc_ff);
         end
         default: add_a = '0;
      endcase
   end

   assign sum = add_a + (add_sub ? ~add_b : add_b) + SUM_BITS'(add_sub);

   always_comb begin
      if (sum[SUM_BITS-1:ACC_BITS-1] == '0 || sum[SUM_BITS-1:ACC_BITS-1] == '1)
         sum_sat = sum[ACC_BITS-1:0];
      else
         sum_sat = sum[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
   end

   assign acc_in = (cmd.acc_op == ACC_LOAD_P || cmd.acc_op == ACC_ADD_P ||
                    cmd.acc_op == ACC_SUB_P) ? sum_sat : acc_ff;

   // output rounding: round half up by 2^24, then clip to the sample width
   logic signed [ACC_BITS:0]           y_round;
   logic signed [Q_BITS-1:0]           q;
   logic [Q_BITS-SAMPLE_BITS:0]        q_top;
   logic                               y_clip;

   assign y_round = {acc_ff[ACC_BITS-1], acc_ff} + ((ACC_BITS + 1)'(1) << (Z_FRAC - 1));
   assign q       = y_round[ACC_BITS:Z_FRAC];
   assign q_top   = q[Q_BITS-1:SAMPLE_BITS-1];
   assign y_clip  = !(q_top == '0 || q_top == '1);
   assign y_in    = !y_clip ? q[SAMPLE_BITS-1:0] : (q[Q_BITS-1] ? Y_MIN : Y_MAX);

   assign x_in = cmd.x_load ? req_sample_in : x_ff;

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in    = cmd.y_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.mul_phase == MUL_LO) begin
         lo_ff  <= pp;
         neg_ff <= s[SAMPLE_BITS-1] ^ c[COEF_BITS-1];
      end
      if (cmd.mul_phase == MUL_HI) hi_ff <= pp;
      if (cmd.mul_phase == MUL_RND) begin
         p_mag_ff <= p_mag_in;
         p_neg_ff <= neg_ff;
      end
      acc_ff <= acc_in;
      if (cmd.y_load) begin
         y_ff           <= y_in;
         rsp_sample_ff  <= y_in;
         rsp_clipped_ff <= y_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < Z_DEPTH; i++) z_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.z_write) z_ff[wr_idx] <= sum_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

// ----- sv/iir_bandpass_df2t_unit.sv -----
// 12th-order IIR bandpass, direct form II transposed, fixed point; top level.
// A new request is taken only when the previous one has finished all its taps,
// as the single 24x32 multiplier forms each product in lo, hi and round steps.
// Reset (synchronous, active high) clears the delay line, FSM and response valid.
// Depends on ibp_pkg, ibp_ctrl and ibp_dp.
module iir_bandpass_df2t_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ibp_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ibp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                   rsp_clipped
);
   import ibp_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer: per request it first forms y = z0 + b0*x, hands y to the
   // response register (waiting only if the previous response is still held),
   // then for each tap computes b*x, a*y and updates the delay element.
   ibp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the multiplier splits each coefficient into two 32-bit halves;
   // the accumulator saturates every sum to 64 bits; the response register
   // parts the two sides so a waiting response does not block the taps.
   ibp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

endmodule

// ----- sv/ibp_checker.sv -----
// Port-level checks for iir_bandpass_df2t_unit, attached by bind.
// Depends on ibp_pkg and the top level's ports.
module ibp_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [ibp_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                                   rsp_clipped
);
   import ibp_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // reset empties the response register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: the next cycle after taking one is busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   // a clipped response sits on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> (rsp_sample_out == Y_MAX || rsp_sample_out == Y_MIN))
      else $error("clipped flag without saturated sample");

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped)))
      else $error("stalled response changed");

endmodule

bind iir_bandpass_df2t_unit ibp_checker u_ibp_checker (.*);
